@@ sv/mplt_pkg.sv @@
// shared types and constants for the mac to phy link table
package mplt_pkg;

  localparam int DEST_ENTRIES_DEF = 16;
  localparam int PIPE_ENTRIES_DEF = 4;
  localparam logic [7:0] MAX_SEND_LEN = 8'd30;
  localparam logic [7:0] MAX_DRAWS = 8'd255;
  localparam logic [7:0] LFSR_TAPS = 8'hB8;

  localparam logic [0:0] CMD_RX = 1'b0;
  localparam logic [0:0] CMD_TX = 1'b1;

  localparam logic [0:0] REG_MY_MAC = 1'b0;
  localparam logic [0:0] REG_SEED = 1'b1;

  typedef struct packed {
    logic [0:0] cmd;
    logic [7:0] peer_mac;
    logic [7:0] rx_reply_phy;
    logic [7:0] length;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic       learned;
    logic [7:0] source_mac;
    logic [7:0] dest_phy;
    logic       ack_enable;
    logic [7:0] reply_phy;
    logic       pipe_opened;
    logic [2:0] pipe_number;
    logic [7:0] payload_len;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DSCAN,
    ST_PSCAN,
    ST_DRAW,
    ST_CHECK,
    ST_FINISH,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic dscan_clr;
    logic dscan_step;
    logic pscan_clr;
    logic pscan_step;
    logic draw;
    logic chk_clr;
    logic chk_step;
    logic finish;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_rx;
    logic too_long;
    logic bcast;
    logic dscan_done;
    logic pscan_done;
    logic need_alloc;
    logic cand_bad;
    logic chk_done;
    logic chk_hit;
    logic draws_left;
  } status_t;

  function automatic logic [7:0] lfsr_next(input logic [7:0] v);
    logic [7:0] s;
    s = {1'b0, v[7:1]};
    if (v[0]) s = s ^ LFSR_TAPS;
    return s;
  endfunction

endpackage

@@ sv/mplt_if.sv @@
// valid/ready channel carrying one item
interface mplt_if #(parameter type item_t = logic) (input logic clk);
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ sv/mac_to_phy_link_table_top.sv @@
// top level of the mac to phy link table
//
// channel   dir  handshake      payload
// in_ch     in   valid/ready    cmd, peer_mac, rx_reply_phy, length
// out_ch    out  valid/ready    accepted ... payload_len
// cfg       in   cfg_we only    cfg_index, cfg_data
//
// one item at a time: accept, walk the learned table (up to DEST_ENTRIES rows), then finish
// and output; a send that is too long or broadcast skips the walks, and any other send
// adds a walk of the pipe table and, when it must open a pipe, lfsr draws, each rejected
// at once if bad or else checked against both tables on the single compare unit
// (255 draws max)
// rst is synchronous and clears counts, lfsr (to 1) and my_mac (to 1)
// the result register holds until taken; a new item is taken after delivery
module mac_to_phy_link_table_top #(
  parameter int DEST_ENTRIES = mplt_pkg::DEST_ENTRIES_DEF,
  parameter int PIPE_ENTRIES = mplt_pkg::PIPE_ENTRIES_DEF
) (
  input logic       clk,
  input logic       rst,
  input logic       cfg_we,
  input logic [0:0] cfg_index,
  input logic [7:0] cfg_data,
  mplt_if.sink      in_ch,
  mplt_if.source    out_ch
);
  import mplt_pkg::*;

  cmd_t    cmd;
  status_t st;

  // controller: state machine only
  mplt_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .st(st), .cmd(cmd)
  );

  // datapath: tables, lfsr, compare unit, result register
  mplt_dp #(.DEST_ENTRIES(DEST_ENTRIES), .PIPE_ENTRIES(PIPE_ENTRIES)) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_item(in_ch.data), .cmd(cmd), .st(st), .out_item(out_ch.data)
  );
endmodule

@@ sv/mplt_ctrl.sv @@
// sequencer for table scans and pipe allocation
module mplt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mplt_pkg::status_t st,
  output mplt_pkg::cmd_t    cmd
);
  import mplt_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          cmd.dscan_clr = 1'b1;
          state_next = ST_DSCAN;
        end
      end
      ST_DSCAN: begin
        if (st.is_rx || (!st.too_long && !st.bcast)) begin
          if (st.dscan_done) begin
            cmd.pscan_clr = 1'b1;
            state_next = st.is_rx ? ST_FINISH : ST_PSCAN;
          end else cmd.dscan_step = 1'b1;
        end else state_next = ST_FINISH;
      end
      ST_PSCAN: begin
        if (st.pscan_done) state_next = st.need_alloc ? ST_DRAW : ST_FINISH;
        else cmd.pscan_step = 1'b1;
      end
      ST_DRAW: begin
        if (!st.draws_left) state_next = ST_FINISH;
        else begin
          cmd.draw = 1'b1;
          cmd.chk_clr = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (st.cand_bad || st.chk_hit) state_next = ST_DRAW;
        else if (st.chk_done) state_next = ST_FINISH;
        else cmd.chk_step = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        cmd.out_load = 1'b1;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule

@@ sv/mplt_dp.sv @@
// tables, lfsr, scan counters and result register
module mplt_dp #(
  parameter int DEST_ENTRIES = mplt_pkg::DEST_ENTRIES_DEF,
  parameter int PIPE_ENTRIES = mplt_pkg::PIPE_ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  mplt_pkg::in_item_t  in_item,
  input  mplt_pkg::cmd_t      cmd,
  output mplt_pkg::status_t   st,
  output mplt_pkg::out_item_t out_item
);
  import mplt_pkg::*;

  localparam int DW = (DEST_ENTRIES > 1) ? $clog2(DEST_ENTRIES) : 1;
  localparam int DCW = $clog2(DEST_ENTRIES + 1);
  localparam int PW = (PIPE_ENTRIES > 1) ? $clog2(PIPE_ENTRIES) : 1;
  localparam int PCW = $clog2(PIPE_ENTRIES + 1);
  localparam int SCW = $clog2(DEST_ENTRIES + PIPE_ENTRIES + 1);

  logic [7:0] dest_mac_col [DEST_ENTRIES];
  logic [7:0] dest_phy_col [DEST_ENTRIES];
  logic [7:0] pipe_mac_col [PIPE_ENTRIES];
  logic [7:0] pipe_phy_col [PIPE_ENTRIES];
  logic [DCW-1:0] dest_count;
  logic [PCW-1:0] pipe_count;
  logic [7:0] my_mac, lfsr_value;

  in_item_t item;
  logic [DCW-1:0] di;
  logic [PCW-1:0] pi;
  logic [SCW-1:0] ci;
  logic dhit, phit;
  logic [7:0] dphy, pphy;
  logic [7:0] draws;
  logic found;

  logic [7:0] dm, dp, pm, pp;
  logic [SCW-1:0] ci_p;
  logic chk_in_dest;

  assign dm = dest_mac_col[di[DW-1:0]];
  assign dp = dest_phy_col[di[DW-1:0]];
  assign pm = pipe_mac_col[pi[PW-1:0]];
  assign pp = pipe_phy_col[pi[PW-1:0]];
  assign ci_p = ci - SCW'(DEST_ENTRIES);
  assign chk_in_dest = ci < SCW'(DEST_ENTRIES);

  logic [7:0] cm, cp;
  always_comb begin
    if (chk_in_dest) begin
      cm = dest_mac_col[ci[DW-1:0]];
      cp = dest_phy_col[ci[DW-1:0]];
    end else begin
      cm = pipe_mac_col[ci_p[PW-1:0]];
      cp = pipe_phy_col[ci_p[PW-1:0]];
    end
  end

  logic chk_valid;
  assign chk_valid = chk_in_dest ? (ci < SCW'(dest_count))
                                 : (ci_p < SCW'(pipe_count));

  always_comb begin
    st.is_rx = item.cmd == CMD_RX;
    st.too_long = item.length > MAX_SEND_LEN;
    st.bcast = item.peer_mac == 8'd0;
    st.dscan_done = dhit || di >= dest_count;
    st.pscan_done = phit || pi >= pipe_count;
    st.need_alloc = !phit && pipe_count < PCW'(PIPE_ENTRIES);
    st.cand_bad = lfsr_value == 8'd0 || lfsr_value == 8'd255 || lfsr_value == my_mac;
    st.chk_done = ci >= SCW'(DEST_ENTRIES + PIPE_ENTRIES);
    st.chk_hit = !st.chk_done && chk_valid && (cm == lfsr_value || cp == lfsr_value);
    st.draws_left = draws != 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      my_mac <= 8'd1;
      lfsr_value <= 8'd1;
      dest_count <= '0;
      pipe_count <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_MY_MAC) my_mac <= cfg_data;
      if (cfg_we && cfg_index == REG_SEED) lfsr_value <= cfg_data;
      else if (cmd.draw) lfsr_value <= lfsr_next(lfsr_value);
      if (cmd.finish) begin
        if (item.cmd == CMD_RX) begin
          if (item.peer_mac != item.rx_reply_phy && !dhit
              && dest_count < DCW'(DEST_ENTRIES)) begin
            dest_mac_col[dest_count[DW-1:0]] <= item.peer_mac;
            dest_phy_col[dest_count[DW-1:0]] <= item.rx_reply_phy;
            dest_count <= dest_count + 1'b1;
          end
        end else if (found) begin
          pipe_mac_col[pipe_count[PW-1:0]] <= item.peer_mac;
          pipe_phy_col[pipe_count[PW-1:0]] <= lfsr_value;
          pipe_count <= pipe_count + 1'b1;
        end
      end
    end
  end

  // scan state
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item <= in_item;
      draws <= MAX_DRAWS;
      found <= 1'b0;
    end
    if (cmd.dscan_clr) begin
      di <= '0;
      dhit <= 1'b0;
    end else if (cmd.dscan_step) begin
      if (dm == item.peer_mac) begin
        dhit <= 1'b1;
        dphy <= dp;
      end else di <= di + 1'b1;
    end
    if (cmd.pscan_clr) begin
      pi <= '0;
      phit <= 1'b0;
    end else if (cmd.pscan_step) begin
      if (pm == item.peer_mac) begin
        phit <= 1'b1;
        pphy <= pp;
      end else pi <= pi + 1'b1;
    end
    if (cmd.draw) draws <= draws - 1'b1;
    if (cmd.chk_clr) ci <= '0;
    else if (cmd.chk_step) begin
      ci <= ci + 1'b1;
      if (ci == SCW'(DEST_ENTRIES + PIPE_ENTRIES - 1)) found <= 1'b1;
    end
  end

  // result assembly
  out_item_t out_next;
  always_comb begin
    out_next = '0;
    if (item.cmd == CMD_RX) begin
      out_next.accepted = 1'b1;
      out_next.learned = item.peer_mac != item.rx_reply_phy && !dhit
                         && dest_count < DCW'(DEST_ENTRIES);
      out_next.source_mac = item.peer_mac;
      out_next.payload_len = item.length - 8'd2;
    end else if (!(item.length > MAX_SEND_LEN)) begin
      out_next.accepted = 1'b1;
      out_next.source_mac = my_mac;
      out_next.payload_len = item.length + 8'd2;
      out_next.reply_phy = my_mac;
      if (item.peer_mac != 8'd0) begin
        out_next.dest_phy = dhit ? dphy : item.peer_mac;
        out_next.ack_enable = dhit;
        if (phit) out_next.reply_phy = pphy;
        else if (found) begin
          out_next.reply_phy = lfsr_value;
          out_next.pipe_opened = 1'b1;
          out_next.pipe_number = 3'(pipe_count) + 3'd2;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_item <= out_next;
  end
endmodule
